>>> rtl/core/nand_page_read_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// NAND page read sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NAND_PAGE_READ_SEQUENCER_UNIT_MACROS_SVH
`define NAND_PAGE_READ_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication.
`define NPRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/nprs_pkg.sv
// ----------------------------------------------------------------------------
// NAND page read sequencer package
// Sequencer phases, bus operation codes, flash commands and the result type.
// ----------------------------------------------------------------------------
package nprs_pkg;

  // Default page size in bytes; must be a power of two.
  localparam int unsigned NPRS_PAGE_BYTES = 2048;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CMD0  = 3'd1,
    PH_ADDR  = 3'd2,
    PH_CMD30 = 3'd3,
    PH_WAIT  = 3'd4,
    PH_READ  = 3'd5,
    PH_DONE  = 3'd6
  } nprs_phase_e;

  // Bus operation codes.
  localparam logic [1:0] OP_IDLE = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_ADDR = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // Large-page read commands.
  localparam logic [7:0] CMD_READ_SETUP   = 8'h00;
  localparam logic [7:0] CMD_READ_CONFIRM = 8'h30;

  // Index of the last of the five address bytes.
  localparam logic [2:0] ADDR_STEP_LAST = 3'd4;

  typedef struct packed {
    logic [1:0] bus_op;
    logic [7:0] bus_byte;
    logic       chip_selected;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       finished;
    logic       busy_res;
  } nprs_result_t;

endpackage

>>> rtl/core/nprs_ctrl.sv
// ----------------------------------------------------------------------------
// NAND page read sequencer control
// Phase state machine and address/length counters; one step per item.
// ----------------------------------------------------------------------------
module nprs_ctrl import nprs_pkg::*; #(
  parameter int unsigned PAGE_BYTES = NPRS_PAGE_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic         start_req_i,
  input  logic [31:0]  start_address_i,
  input  logic [31:0]  read_length_i,
  input  logic         flash_ready_i,
  input  logic [7:0]   read_data_i,
  output nprs_result_t res_o
);

  localparam int unsigned PageLog = $clog2(PAGE_BYTES);

  nprs_phase_e phase_q, phase_d;
  logic [2:0]  step_q, step_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] left_q, left_d;

  logic [15:0] col_w;
  logic [23:0] row_w;
  logic [7:0]  addr_byte;
  logic        page_end;

  // The column always equals the low address bits, so the page ends when they are all ones.
  assign col_w    = 16'(addr_q[PageLog-1:0]);
  assign row_w    = 24'(addr_q >> PageLog);
  assign page_end = &addr_q[PageLog-1:0];

  always_comb begin
    unique case (step_q)
      3'd0:    addr_byte = col_w[7:0];
      3'd1:    addr_byte = col_w[15:8];
      3'd2:    addr_byte = row_w[7:0];
      3'd3:    addr_byte = row_w[15:8];
      default: addr_byte = row_w[23:16];
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    addr_d  = addr_q;
    left_d  = left_q;
    res_o   = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          if (read_length_i == 32'd0) begin
            res_o.finished = 1'b1;
          end else begin
            addr_d              = start_address_i;
            left_d              = read_length_i;
            step_d              = '0;
            res_o.chip_selected = 1'b1;
            res_o.busy_res      = 1'b1;
            phase_d             = PH_CMD0;
          end
        end
      end
      PH_CMD0: begin
        res_o.bus_op        = OP_CMD;
        res_o.bus_byte      = CMD_READ_SETUP;
        res_o.chip_selected = 1'b1;
        res_o.busy_res      = 1'b1;
        step_d              = '0;
        phase_d             = PH_ADDR;
      end
      PH_ADDR: begin
        res_o.bus_op        = OP_ADDR;
        res_o.bus_byte      = addr_byte;
        res_o.chip_selected = 1'b1;
        res_o.busy_res      = 1'b1;
        if (step_q >= ADDR_STEP_LAST) begin
          step_d  = '0;
          phase_d = PH_CMD30;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      PH_CMD30: begin
        res_o.bus_op        = OP_CMD;
        res_o.bus_byte      = CMD_READ_CONFIRM;
        res_o.chip_selected = 1'b1;
        res_o.busy_res      = 1'b1;
        phase_d             = PH_WAIT;
      end
      PH_WAIT: begin
        res_o.chip_selected = 1'b1;
        res_o.busy_res      = 1'b1;
        if (flash_ready_i) begin
          phase_d = PH_READ;
        end
      end
      PH_READ: begin
        res_o.bus_op        = OP_READ;
        res_o.chip_selected = 1'b1;
        res_o.busy_res      = 1'b1;
        res_o.data_valid    = 1'b1;
        res_o.data_byte     = read_data_i;
        addr_d              = addr_q + 32'd1;
        left_d              = left_q - 32'd1;
        if (left_q == 32'd1) begin
          phase_d = PH_DONE;
        end else if (page_end) begin
          phase_d = PH_CMD0;
        end
      end
      PH_DONE: begin
        res_o.finished = 1'b1;
        phase_d        = PH_IDLE;
      end
      default: begin
        res_o.finished = 1'b1;
        phase_d        = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
      addr_q  <= '0;
      left_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      step_q  <= step_d;
      addr_q  <= addr_d;
      left_q  <= left_d;
    end
  end

endmodule

>>> rtl/core/nprs_out_reg.sv
// ----------------------------------------------------------------------------
// NAND page read sequencer output register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module nprs_out_reg import nprs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  nprs_result_t res_i,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output nprs_result_t res_o,
  output logic         in_stall_o
);

  logic         valid_q, valid_d;
  nprs_result_t res_q;

  // The register may be refilled in the same cycle that its item is taken.
  assign in_stall_o = valid_q & out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/core/nand_page_read_sequencer_unit.sv
// ----------------------------------------------------------------------------
// NAND page read sequencer unit
// Drives the command, address and data cycles of a large-page NAND read.
// ----------------------------------------------------------------------------
// Each input item is one flash interface cycle: a start request with address
// and length, the ready/busy line and the byte on the data bus. Each accepted
// item yields exactly one result item telling what the bus does in that cycle.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The input channel is stalled only while the output register
// holds an item and the receiver stalls it.
// Throughput is one item per cycle unless the output stalls: the phase machine
// steps once per item and its result is written straight into the output
// register, so a result appears in the cycle after its item is accepted.
// Per page the sequence is command 0x00, five address bytes (two column and
// three row bytes), command 0x30, a wait for ready, then the data cycles.
// PAGE_BYTES must be a power of two; column and row come from address bits.
// Reset clears the phase machine to idle and empties the output register;
// no clearing pass is needed, so items are accepted right after reset.
// ----------------------------------------------------------------------------
module nand_page_read_sequencer_unit import nprs_pkg::*; #(
  parameter int unsigned PAGE_BYTES = NPRS_PAGE_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_req_i,
  input  logic [31:0] start_address_i,
  input  logic [31:0] read_length_i,
  input  logic        flash_ready_i,
  input  logic [7:0]  read_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  bus_op_o,
  output logic [7:0]  bus_byte_o,
  output logic        chip_selected_o,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic        finished_o,
  output logic        busy_res_o
);

  logic         accept;
  nprs_result_t step_res;
  nprs_result_t out_res;

  // An item is taken whenever it is offered and the output side has room.
  assign accept = in_valid_i & ~in_stall_o;

  nprs_ctrl #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .start_req_i    (start_req_i),
    .start_address_i(start_address_i),
    .read_length_i  (read_length_i),
    .flash_ready_i  (flash_ready_i),
    .read_data_i    (read_data_i),
    .res_o          (step_res)
  );

  nprs_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .res_i      (step_res),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .res_o      (out_res),
    .in_stall_o (in_stall_o)
  );

  // The result register fields map one to one onto the output ports.
  assign bus_op_o        = out_res.bus_op;
  assign bus_byte_o      = out_res.bus_byte;
  assign chip_selected_o = out_res.chip_selected;
  assign data_valid_o    = out_res.data_valid;
  assign data_byte_o     = out_res.data_byte;
  assign finished_o      = out_res.finished;
  assign busy_res_o      = out_res.busy_res;

endmodule

>>> rtl/core/nprs_checker.sv
// ----------------------------------------------------------------------------
// NAND page read sequencer checker
// Port-level assertions on the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "nand_page_read_sequencer_unit_macros.svh"

module nprs_checker import nprs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  bus_op_o,
  input logic [7:0]  bus_byte_o,
  input logic        chip_selected_o,
  input logic        data_valid_o,
  input logic [7:0]  data_byte_o,
  input logic        finished_o,
  input logic        busy_res_o
);

  // A stalled result item holds its place and its contents.
  `NPRS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(bus_op_o) && $stable(bus_byte_o) &&
                    $stable(data_byte_o) && $stable(finished_o),
                    "stalled result item changed")

  // Every accepted item produces a result item in the next cycle.
  `NPRS_ASSERT_NEXT(a_accept_to_out, in_valid_i && !in_stall_o, out_valid_o,
                    "accepted item produced no result")

  // The input side is stalled only by a full, stalled output register.
  `NPRS_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
                   "input stalled without cause")

  // A finish item releases the chip and drives no bus cycle.
  `NPRS_ASSERT_NOW(a_finish_idle, out_valid_o && finished_o,
                   !busy_res_o && !chip_selected_o && bus_op_o == OP_IDLE &&
                   !data_valid_o,
                   "finish item not idle")

endmodule

bind nand_page_read_sequencer_unit nprs_checker u_nprs_checker (.*);
